### rtl/bhc_pkg.sv
// shared types, constants and tables of the blob hue color classifier
`timescale 1ns / 1ps
`default_nettype none
package bhc_pkg;

  localparam int unsigned MaxPixels    = 65536;
  localparam int unsigned HistoryDepth = 20;
  localparam int unsigned CntW         = $clog2(MaxPixels + 1);
  localparam int unsigned HistIdxW     = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned HistFillW    = $clog2(HistoryDepth + 1);
  localparam int unsigned SumW         = CntW + 8;
  localparam int unsigned TrigSumW     = CntW + 17;
  localparam int unsigned CordicSteps  = 14;
  // step index serves the cordic, scoring and vote passes
  localparam int unsigned StepW        = (CordicSteps > HistoryDepth) ? $clog2(CordicSteps)
                                                                      : $clog2(HistoryDepth);
  localparam int unsigned CordW        = TrigSumW + 2;
  localparam int unsigned ZW           = 18;
  localparam int unsigned ProtoCount   = 7;
  localparam int unsigned ProtoW       = $clog2(ProtoCount);
  localparam int unsigned ClassSlots   = 8;
  localparam int unsigned HueTurn      = 46080;
  localparam int unsigned HueHalfTurn  = 23040;
  localparam int unsigned ScoreW       = 40;
  localparam int unsigned CfgAddrW     = 1;

  localparam logic [CfgAddrW-1:0] CfgSatThr = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgValThr = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accum;      // add the pixel at the input
    logic start_div;  // start mean division
    logic cordic_init;
    logic cordic_step;
    logic score_step;
    logic push;       // push class into history
    logic vote_step;
    logic load_out;
    logic clear;
  } bhc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic has_pixels;
  } bhc_status_t;

  function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
    logic [14:0] r;
    case (idx)
      6'd0: r = 15'd0;      6'd1: r = 15'd1144;   6'd2: r = 15'd2286;
      6'd3: r = 15'd3425;   6'd4: r = 15'd4560;   6'd5: r = 15'd5690;
      6'd6: r = 15'd6813;   6'd7: r = 15'd7927;   6'd8: r = 15'd9032;
      6'd9: r = 15'd10126;  6'd10: r = 15'd11207; 6'd11: r = 15'd12275;
      6'd12: r = 15'd13328; 6'd13: r = 15'd14364; 6'd14: r = 15'd15383;
      6'd15: r = 15'd16384; 6'd16: r = 15'd17364; 6'd17: r = 15'd18323;
      6'd18: r = 15'd19260; 6'd19: r = 15'd20173; 6'd20: r = 15'd21062;
      6'd21: r = 15'd21925; 6'd22: r = 15'd22762; 6'd23: r = 15'd23571;
      6'd24: r = 15'd24351; 6'd25: r = 15'd25101; 6'd26: r = 15'd25821;
      6'd27: r = 15'd26509; 6'd28: r = 15'd27165; 6'd29: r = 15'd27788;
      6'd30: r = 15'd28377; 6'd31: r = 15'd28932; 6'd32: r = 15'd29451;
      6'd33: r = 15'd29934; 6'd34: r = 15'd30381; 6'd35: r = 15'd30791;
      6'd36: r = 15'd31163; 6'd37: r = 15'd31498; 6'd38: r = 15'd31794;
      6'd39: r = 15'd32051; 6'd40: r = 15'd32269; 6'd41: r = 15'd32448;
      6'd42: r = 15'd32587; 6'd43: r = 15'd32687; 6'd44: r = 15'd32747;
      6'd45: r = 15'd32767;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] cordic_angle(input logic [StepW-1:0] i);
    logic [12:0] r;
    case (i)
      4'd0: r = 13'd5760; 4'd1: r = 13'd3400; 4'd2: r = 13'd1797; 4'd3: r = 13'd912;
      4'd4: r = 13'd458;  4'd5: r = 13'd229;  4'd6: r = 13'd115;  4'd7: r = 13'd57;
      4'd8: r = 13'd29;   4'd9: r = 13'd14;   4'd10: r = 13'd7;   4'd11: r = 13'd4;
      4'd12: r = 13'd2;   4'd13: r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] proto_hue(input logic [ProtoW-1:0] i);
    logic [15:0] r;
    case (i)
      3'd1: r = 16'd25600; 3'd2: r = 16'd32000; 3'd3: r = 16'd15360;
      3'd4: r = 16'd7680;  3'd6: r = 16'd46080;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] proto_class(input logic [ProtoW-1:0] i);
    logic [2:0] r;
    case (i)
      3'd1, 3'd2: r = 3'd1;
      3'd3: r = 3'd2;
      3'd4: r = 3'd3;
      3'd5, 3'd6: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/bhc_stream_if.sv
// valid/ready stream interfaces for pixels and results
`timescale 1ns / 1ps
`default_nettype none
interface bhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] sat;
  logic [7:0] val;
  logic       inside_shape;
  logic       last_pixel;
  modport source (output valid, hue, sat, val, inside_shape, last_pixel, input ready);
  modport sink (input valid, hue, sat, val, inside_shape, last_pixel, output ready);
endinterface

interface bhc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  color_index;
  logic [15:0] mean_hue;
  logic [15:0] mean_sat;
  logic [15:0] mean_val;
  logic [16:0] valid_count;
  modport source (output valid, color_index, mean_hue, mean_sat, mean_val, valid_count,
                  input ready);
  modport sink (input valid, color_index, mean_hue, mean_sat, mean_val, valid_count,
                output ready);
endinterface
`default_nettype wire

### rtl/blob_hue_color_classifier.sv
// top level of the blob hue color classifier
// Pixels of one region arrive on pix (valid/ready), results leave on res
// (valid/ready), and cfg is a plain write port for the two thresholds:
// index 0 saturation, index 1 value, both reset to 30.
// A pixel counts when it lies inside the shape and its saturation and value
// exceed the thresholds. Ordinary pixels transfer one per cycle.
// A pixel flagged last_pixel ends the region and intake stops while the block
// starts the mean dividers, runs them (one quotient bit per cycle over
// SumW+9 = 34 bits), sets up the cordic, runs 14 cordic steps, scores
// 7 prototypes, votes over 20 history entries and loads the output register.
// The result sits in an output register until res is ready; pixel intake
// resumes only in the cycle the result transfers, so a stalled receiver
// stalls the pixel stream too.
// Reset clears the sums, the history fill and head, and loads both
// thresholds with 30; history entries are read only after they were written.
`timescale 1ns / 1ps
`default_nettype none
module blob_hue_color_classifier (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bhc_pixel_if.sink   pix,
  bhc_result_if.source res,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i
);
  import bhc_pkg::*;

  bhc_cmd_t         cmd;
  bhc_status_t      status;
  logic [StepW-1:0] step;

  // controller
  bhc_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (pix.valid),
    .in_last_i  (pix.last_pixel),
    .in_ready_o (pix.ready),
    .out_valid_o(res.valid),
    .out_ready_i(res.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .step_o     (step)
  );

  // datapath
  bhc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .hue_i        (pix.hue),
    .sat_i        (pix.sat),
    .val_i        (pix.val),
    .inside_i     (pix.inside_shape),
    .step_i       (step),
    .color_index_o(res.color_index),
    .mean_hue_o   (res.mean_hue),
    .mean_sat_o   (res.mean_sat),
    .mean_val_o   (res.mean_val),
    .valid_count_o(res.valid_count)
  );

endmodule
`default_nettype wire

### rtl/bhc_divider.sv
// radix-2 restoring divider for the rounded 8.8 means
`timescale 1ns / 1ps
`default_nettype none
module bhc_divider (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [bhc_pkg::SumW+8:0] dividend_i,
  input  wire logic [bhc_pkg::CntW-1:0] divisor_i,
  output logic                         done_o,
  output logic [15:0]                  quotient_o
);
  import bhc_pkg::*;

  localparam int unsigned NW  = SumW + 9;
  localparam int unsigned BW  = $clog2(NW + 1);

  logic [NW-1:0]   num_q, num_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [BW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [CntW:0]   trial;

  // one quotient bit per cycle, shifted into the numerator register
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[CntW-1:0], num_q[NW-1]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = BW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = num_q[15:0];

endmodule
`default_nettype wire

### rtl/bhc_datapath.sv
// accumulators, mean dividers, cordic, prototype scoring and history vote
`timescale 1ns / 1ps
`default_nettype none
module bhc_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bhc_pkg::bhc_cmd_t    cmd_i,
  output bhc_pkg::bhc_status_t      status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_addr_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic [7:0]           hue_i,
  input  wire logic [7:0]           sat_i,
  input  wire logic [7:0]           val_i,
  input  wire logic                 inside_i,
  input  wire logic [bhc_pkg::StepW-1:0] step_i,
  output logic [2:0]                color_index_o,
  output logic [15:0]               mean_hue_o,
  output logic [15:0]               mean_sat_o,
  output logic [15:0]               mean_val_o,
  output logic [16:0]               valid_count_o
);
  import bhc_pkg::*;

  logic [7:0]            sat_thr_q, val_thr_q;
  logic [CntW-1:0]       count_q;
  logic [SumW-1:0]       ssum_q, vsum_q;
  logic signed [TrigSumW-1:0] csum_q, ssin_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_thr_q <= 8'd30;
      val_thr_q <= 8'd30;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CfgSatThr) sat_thr_q <= cfg_data_i;
      else val_thr_q <= cfg_data_i;
    end
  end

  // hue to sin/cos through the quarter table
  logic [7:0] h;
  logic signed [15:0] cos_v, sin_v;
  always_comb begin
    h = (hue_i >= 8'd180) ? hue_i - 8'd180 : hue_i;
    if (h <= 8'd45) begin
      sin_v = 16'(quarter_sine(h[5:0]));
      cos_v = 16'(quarter_sine(6'(8'd45 - h)));
    end else if (h <= 8'd90) begin
      sin_v = 16'(quarter_sine(6'(8'd90 - h)));
      cos_v = -16'(quarter_sine(6'(h - 8'd45)));
    end else if (h <= 8'd135) begin
      sin_v = -16'(quarter_sine(6'(h - 8'd90)));
      cos_v = -16'(quarter_sine(6'(8'd135 - h)));
    end else begin
      sin_v = -16'(quarter_sine(6'(8'd180 - h)));
      cos_v = 16'(quarter_sine(6'(h - 8'd135)));
    end
  end

  logic pix_ok;
  assign pix_ok = inside_i && (sat_i > sat_thr_q) && (val_i > val_thr_q)
                  && (count_q < CntW'(MaxPixels));

  // region accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; ssum_q <= '0; vsum_q <= '0; csum_q <= '0; ssin_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0; ssum_q <= '0; vsum_q <= '0; csum_q <= '0; ssin_q <= '0;
    end else if (cmd_i.accum && pix_ok) begin
      count_q <= count_q + 1'b1;
      ssum_q  <= ssum_q + SumW'(sat_i);
      vsum_q  <= vsum_q + SumW'(val_i);
      csum_q  <= csum_q + TrigSumW'(cos_v);
      ssin_q  <= ssin_q + TrigSumW'(sin_v);
    end
  end

  // rounded means: (sum*256 + n/2) / n
  logic [SumW+8:0] s_num, v_num;
  logic [15:0]     ms, mv;
  logic            sdone, vdone;
  assign s_num = {1'b0, ssum_q, 8'd0} + (SumW+9)'(count_q >> 1);
  assign v_num = {1'b0, vsum_q, 8'd0} + (SumW+9)'(count_q >> 1);

  bhc_divider u_sdiv (.clk_i, .rst_ni, .start_i(cmd_i.start_div), .dividend_i(s_num),
                      .divisor_i(count_q), .done_o(sdone), .quotient_o(ms));
  bhc_divider u_vdiv (.clk_i, .rst_ni, .start_i(cmd_i.start_div), .dividend_i(v_num),
                      .divisor_i(count_q), .done_o(vdone), .quotient_o(mv));

  assign status_o.div_done   = sdone && vdone;
  assign status_o.has_pixels = (count_q != '0);

  // cordic vectoring, one step per cycle
  logic signed [CordW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0]    z_q;
  logic                    zero_q;
  assign xs = x_q >>> step_i;
  assign ys = y_q >>> step_i;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) begin
      zero_q <= (csum_q == '0) && (ssin_q == '0);
      if (csum_q < 0) begin
        x_q <= -CordW'(csum_q);
        y_q <= -CordW'(ssin_q);
        z_q <= ZW'(HueHalfTurn);
      end else begin
        x_q <= CordW'(csum_q);
        y_q <= CordW'(ssin_q);
        z_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ZW'(cordic_angle(step_i));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ZW'(cordic_angle(step_i));
      end
    end
  end

  logic [15:0] mh;
  always_comb begin
    if (zero_q || !status_o.has_pixels) mh = '0;
    else if (z_q < 0) mh = 16'(z_q + ZW'(HueTurn));
    else if (z_q >= ZW'(HueTurn)) mh = 16'(z_q - ZW'(HueTurn));
    else mh = z_q[15:0];
  end

  // prototype scoring, one prototype per cycle
  logic [ProtoW-1:0] pidx;
  assign pidx = step_i[ProtoW-1:0];
  logic [16:0] dh, dh2, ds, dv;
  logic [15:0] ph;
  logic [ScoreW-1:0] score, best_q;
  logic [2:0]        cls_q;
  always_comb begin
    ph  = proto_hue(pidx);
    dh  = (mh > ph) ? 17'(mh - ph) : 17'(ph - mh);
    dh2 = (17'(HueTurn) - dh < dh) ? 17'(HueTurn) - dh : dh;
    if (pidx == '0) begin
      ds = 17'(ms);
      dv = 17'(mv);
    end else begin
      ds = (ms > 16'hFF00) ? 17'(ms - 16'hFF00) : 17'(16'hFF00 - ms);
      dv = (mv > 16'h8000) ? 17'(mv - 16'h8000) : 17'(16'h8000 - mv);
    end
    score = (ScoreW'(dh2) * ScoreW'(dh2) << 4) + (ScoreW'(ds) * ScoreW'(ds) << 2)
            + ScoreW'(dv) * ScoreW'(dv);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.score_step && (pidx == '0 || score < best_q)) begin
      best_q <= score;
      cls_q  <= proto_class(pidx);
    end
  end

  // history ring and vote
  logic [2:0]           hist_q [HistoryDepth];
  logic [HistIdxW-1:0]  head_q;
  logic [HistFillW-1:0] fill_q;
  logic [4:0]           cnt_q [ClassSlots];
  logic [HistIdxW-1:0]  vidx;
  logic [2:0]           newcls;
  assign newcls = status_o.has_pixels ? cls_q : 3'd0;
  assign vidx   = HistIdxW'(step_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) hist_q[head_q] <= newcls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.push) begin
      head_q <= (head_q == HistIdxW'(HistoryDepth - 1)) ? '0 : head_q + 1'b1;
      if (fill_q < HistFillW'(HistoryDepth)) fill_q <= fill_q + 1'b1;
    end
  end

  // count pass over the written entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int k = 0; k < ClassSlots; k++) cnt_q[k] <= '0;
    end else if (cmd_i.vote_step) begin
      if (32'(step_i) < 32'(fill_q)) cnt_q[hist_q[vidx]] <= cnt_q[hist_q[vidx]] + 1'b1;
    end
  end

  // argmax over class slots, lowest class on ties
  logic [2:0] arg;
  always_comb begin
    arg = '0;
    for (int k = 1; k < ClassSlots; k++)
      if (cnt_q[k] > cnt_q[arg]) arg = 3'(k);
  end

  // output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      color_index_o <= arg;
      mean_hue_o    <= mh;
      mean_sat_o    <= status_o.has_pixels ? ms : '0;
      mean_val_o    <= status_o.has_pixels ? mv : '0;
      valid_count_o <= 17'(count_q);
    end
  end

endmodule
`default_nettype wire

### rtl/bhc_controller.sv
// sequencer for accumulation and end-of-region classification
`timescale 1ns / 1ps
`default_nettype none
module bhc_controller (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_last_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire bhc_pkg::bhc_status_t  status_i,
  output bhc_pkg::bhc_cmd_t          cmd_o,
  output logic [bhc_pkg::StepW-1:0]  step_o
);
  import bhc_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC, ST_START, ST_DIV, ST_CINIT, ST_CORDIC, ST_SCORE, ST_VOTE, ST_LOAD, ST_OUT
  } state_e;

  localparam int unsigned VoteW = $clog2(HistoryDepth + 1);

  state_e          state_q;
  logic [StepW-1:0] step_q;
  logic [VoteW-1:0] vcnt_q;
  logic            fire;

  assign in_ready_o  = (state_q == ST_ACC) || (state_q == ST_OUT && out_ready_i);
  assign out_valid_o = (state_q == ST_OUT);
  assign fire        = in_valid_i && in_ready_o;

  // the vote counter replaces the step counter on step_o in the vote pass
  assign step_o = (state_q == ST_VOTE) ? StepW'(vcnt_q) : step_q;

  // dividers start once the last pixel is in the sums
  always_comb begin
    cmd_o             = '0;
    cmd_o.accum       = fire;
    cmd_o.start_div   = (state_q == ST_START);
    cmd_o.cordic_init = (state_q == ST_CINIT);
    cmd_o.cordic_step = (state_q == ST_CORDIC);
    cmd_o.score_step  = (state_q == ST_SCORE);
    cmd_o.push        = (state_q == ST_SCORE) && (step_q == StepW'(ProtoCount - 1));
    cmd_o.vote_step   = (state_q == ST_VOTE);
    cmd_o.load_out    = (state_q == ST_LOAD);
    cmd_o.clear       = (state_q == ST_LOAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q  <= '0;
      vcnt_q  <= '0;
    end else begin
      case (state_q)
        ST_ACC, ST_OUT: begin
          if (state_q == ST_OUT && out_ready_i) state_q <= ST_ACC;
          if (fire && in_last_i) state_q <= ST_START;
        end
        ST_START: state_q <= ST_DIV;
        ST_DIV:   if (status_i.div_done) state_q <= ST_CINIT;
        ST_CINIT: begin
          step_q  <= '0;
          state_q <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (step_q == StepW'(CordicSteps - 1)) begin
            step_q  <= '0;
            state_q <= ST_SCORE;
          end else step_q <= step_q + 1'b1;
        end
        ST_SCORE: begin
          if (step_q == StepW'(ProtoCount - 1)) begin
            vcnt_q  <= '0;
            state_q <= ST_VOTE;
          end else step_q <= step_q + 1'b1;
        end
        ST_VOTE: begin
          if (vcnt_q == VoteW'(HistoryDepth - 1)) state_q <= ST_LOAD;
          else vcnt_q <= vcnt_q + 1'b1;
        end
        ST_LOAD: state_q <= ST_OUT;
        default: state_q <= ST_ACC;
      endcase
    end
  end

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  // no pixel taken while classifying
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACC && state_q != ST_OUT) |-> !in_ready_o)
    else $error("pixel accepted during classification");
  // a last pixel always starts the division
  a_last_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_i |=> state_q == ST_START)
    else $error("last pixel did not start classification");

endmodule
`default_nettype wire
